// ===== src/pwcr_pkg.sv =====
`timescale 1ns / 1ps

package pwcr_pkg;

	// Widths fixed by the register map and the item fields.
	localparam int TimerW   = 16;
	localparam int StepW    = 10;
	localparam int CodeOutW = 32;
	localparam int AddrW    = 5;
	localparam int DataW    = 32;

	localparam int CODE_WIDTH_DEF = 32;

	localparam logic [TimerW-1:0] TIMER_MAX = '1;

	// Reset values of the configuration registers.
	localparam logic [TimerW-1:0] START_MIN_RST = 16'd3500;
	localparam logic [TimerW-1:0] START_MAX_RST = 16'd5000;
	localparam logic [TimerW-1:0] ONE_MIN_RST   = 16'd1200;
	localparam logic [TimerW-1:0] ONE_MAX_RST   = 16'd2000;
	localparam logic [TimerW-1:0] ZERO_MIN_RST  = 16'd100;
	localparam logic [TimerW-1:0] ZERO_MAX_RST  = 16'd800;
	localparam logic [TimerW-1:0] TIMEOUT_RST   = 16'd10000;
	localparam logic [StepW-1:0]  TICK_STEP_RST = 10'd10;

	// Register index, taken from the word address.
	typedef enum logic [2:0] {
		REG_START_MIN = 3'd0,
		REG_START_MAX = 3'd1,
		REG_ONE_MIN   = 3'd2,
		REG_ONE_MAX   = 3'd3,
		REG_ZERO_MIN  = 3'd4,
		REG_ZERO_MAX  = 3'd5,
		REG_TIMEOUT   = 3'd6,
		REG_TICK_STEP = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [TimerW-1:0] start_min;
		logic [TimerW-1:0] start_max;
		logic [TimerW-1:0] one_min;
		logic [TimerW-1:0] one_max;
		logic [TimerW-1:0] zero_min;
		logic [TimerW-1:0] zero_max;
		logic [TimerW-1:0] timeout_width;
		logic [StepW-1:0]  tick_step;
	} cfg_t;

	typedef struct packed {
		logic [CodeOutW-1:0] code_bits;
		logic                receiving;
		logic                frame_end;
		logic                bit_taken;
	} res_t;

endpackage

// ===== src/pwcr_in_if.sv =====
`timescale 1ns / 1ps

interface pwcr_in_if;
	logic valid;
	logic ready;
	logic line_level;

	modport source (output valid, output line_level, input ready);
	modport sink (input valid, input line_level, output ready);
endinterface

// ===== src/pwcr_out_if.sv =====
`timescale 1ns / 1ps

interface pwcr_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] code_bits;
	logic        receiving;
	logic        frame_end;
	logic        bit_taken;

	modport source (output valid, output code_bits, output receiving, output frame_end,
		output bit_taken, input ready);
	modport sink (input valid, input code_bits, input receiving, input frame_end,
		input bit_taken, output ready);
endinterface

// ===== src/pwcr_cfg.sv =====
`timescale 1ns / 1ps

module pwcr_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pwcr_pkg::AddrW-1:0]  paddr,
	input  logic [pwcr_pkg::DataW-1:0]  pwdata,
	output logic [pwcr_pkg::DataW-1:0]  prdata,
	output logic                        pready,
	output pwcr_pkg::cfg_t              cfg
);
	import pwcr_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx   = reg_idx_t'(paddr[AddrW-1:2]);
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg   = cfg_q;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_min     <= START_MIN_RST;
			cfg_q.start_max     <= START_MAX_RST;
			cfg_q.one_min       <= ONE_MIN_RST;
			cfg_q.one_max       <= ONE_MAX_RST;
			cfg_q.zero_min      <= ZERO_MIN_RST;
			cfg_q.zero_max      <= ZERO_MAX_RST;
			cfg_q.timeout_width <= TIMEOUT_RST;
			cfg_q.tick_step     <= TICK_STEP_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_START_MIN: cfg_q.start_min     <= pwdata[TimerW-1:0];
				REG_START_MAX: cfg_q.start_max     <= pwdata[TimerW-1:0];
				REG_ONE_MIN:   cfg_q.one_min       <= pwdata[TimerW-1:0];
				REG_ONE_MAX:   cfg_q.one_max       <= pwdata[TimerW-1:0];
				REG_ZERO_MIN:  cfg_q.zero_min      <= pwdata[TimerW-1:0];
				REG_ZERO_MAX:  cfg_q.zero_max      <= pwdata[TimerW-1:0];
				REG_TIMEOUT:   cfg_q.timeout_width <= pwdata[TimerW-1:0];
				REG_TICK_STEP: cfg_q.tick_step     <= pwdata[StepW-1:0];
			endcase
		end
	end

	// Read-back mux.
	always_comb begin
		unique case (idx)
			REG_START_MIN: prdata = DataW'(cfg_q.start_min);
			REG_START_MAX: prdata = DataW'(cfg_q.start_max);
			REG_ONE_MIN:   prdata = DataW'(cfg_q.one_min);
			REG_ONE_MAX:   prdata = DataW'(cfg_q.one_max);
			REG_ZERO_MIN:  prdata = DataW'(cfg_q.zero_min);
			REG_ZERO_MAX:  prdata = DataW'(cfg_q.zero_max);
			REG_TIMEOUT:   prdata = DataW'(cfg_q.timeout_width);
			REG_TICK_STEP: prdata = DataW'(cfg_q.tick_step);
		endcase
	end

endmodule

// ===== src/pwcr_decode.sv =====
`timescale 1ns / 1ps

module pwcr_decode #(
	parameter int CODE_WIDTH = pwcr_pkg::CODE_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic           level,
	input  pwcr_pkg::cfg_t cfg,
	output pwcr_pkg::res_t res
);
	import pwcr_pkg::*;

	localparam int ExtW = (CODE_WIDTH > CodeOutW) ? CODE_WIDTH : CodeOutW;

	logic                  was_high_q, armed_q;
	logic [TimerW-1:0]     high_timer_q, low_timer_q;
	logic [CODE_WIDTH-1:0] code_q;

	logic                  was_high_d, armed_d;
	logic [TimerW-1:0]     high_timer_d, low_timer_d;
	logic [CODE_WIDTH-1:0] code_d;
	logic                  end_d, taken_d;

	logic [TimerW:0]       timer_sum;
	logic [TimerW-1:0]     timer_sat;
	logic                  in_start, in_one, in_zero;
	logic [ExtW-1:0]       code_ext;

	// One shared adder: only the timer of the current steady level advances.
	assign timer_sum = (level ? {1'b0, high_timer_q} : {1'b0, low_timer_q})
		+ (TimerW+1)'(cfg.tick_step);
	assign timer_sat = timer_sum[TimerW] ? TIMER_MAX : timer_sum[TimerW-1:0];

	// Window checks on the finished high width.
	assign in_start = (high_timer_q >= cfg.start_min) && (high_timer_q <= cfg.start_max);
	assign in_one   = (high_timer_q >= cfg.one_min) && (high_timer_q <= cfg.one_max);
	assign in_zero  = (high_timer_q >= cfg.zero_min) && (high_timer_q <= cfg.zero_max);

	// Next state for one line sample.
	always_comb begin
		was_high_d   = was_high_q;
		armed_d      = armed_q;
		high_timer_d = high_timer_q;
		low_timer_d  = low_timer_q;
		code_d       = code_q;
		end_d        = 1'b0;
		taken_d      = 1'b0;
		if (level) begin
			if (!was_high_q) begin
				was_high_d   = 1'b1;
				high_timer_d = '0;
			end else begin
				high_timer_d = timer_sat;
				if (timer_sat > cfg.timeout_width && armed_q) begin
					armed_d = 1'b0;
					end_d   = 1'b1;
				end
			end
		end else begin
			if (was_high_q) begin
				was_high_d  = 1'b0;
				low_timer_d = '0;
				if (!armed_q) begin
					armed_d = in_start;
				end else begin
					// Overlapping windows shift a one and then a zero.
					if (in_one) begin
						code_d  = {code_d[CODE_WIDTH-2:0], 1'b1};
						taken_d = 1'b1;
					end
					if (in_zero) begin
						code_d  = {code_d[CODE_WIDTH-2:0], 1'b0};
						taken_d = 1'b1;
					end
				end
			end else begin
				low_timer_d = timer_sat;
				if (timer_sat > cfg.timeout_width && armed_q) begin
					armed_d = 1'b0;
					end_d   = 1'b1;
				end
			end
		end
	end

	// State registers, updated once per sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_high_q   <= 1'b0;
			armed_q      <= 1'b0;
			high_timer_q <= '0;
			low_timer_q  <= '0;
			code_q       <= '0;
		end else if (step) begin
			was_high_q   <= was_high_d;
			armed_q      <= armed_d;
			high_timer_q <= high_timer_d;
			low_timer_q  <= low_timer_d;
			code_q       <= code_d;
		end
	end

	// Result of this sample.
	assign code_ext      = ExtW'(code_d);
	assign res.code_bits = code_ext[CodeOutW-1:0];
	assign res.receiving = armed_d;
	assign res.frame_end = end_d;
	assign res.bit_taken = taken_d;

endmodule

// ===== src/pulse_width_code_receiver.sv =====
`timescale 1ns / 1ps
// A line sample passes the input register, then the output register.
// One sample per cycle unless the output stalls; the decode is a single pass.
// The output register lets a new sample in while the last result waits.
// Reset (arst_n low, asynchronous) clears the timers, armed flag and code,
// and loads the configuration registers with their default values.

module pulse_width_code_receiver #(
	parameter int CODE_WIDTH = pwcr_pkg::CODE_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	pwcr_in_if.sink                     sample,
	pwcr_out_if.source                  result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pwcr_pkg::AddrW-1:0]  paddr,
	input  logic [pwcr_pkg::DataW-1:0]  pwdata,
	output logic [pwcr_pkg::DataW-1:0]  prdata,
	output logic                        pready
);
	import pwcr_pkg::*;

	cfg_t cfg;
	res_t res_d;
	res_t res_s2;
	logic valid_s1, level_s1, valid_s2;
	logic advance;

	pwcr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pwcr_decode #(
		.CODE_WIDTH (CODE_WIDTH)
	) u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.level  (level_s1),
		.cfg    (cfg),
		.res    (res_d)
	);

	// Stage 1 moves into the output register when that register is free.
	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign sample.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			level_s1 <= sample.line_level;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign result.valid     = valid_s2;
	assign result.code_bits = res_s2.code_bits;
	assign result.receiving = res_s2.receiving;
	assign result.frame_end = res_s2.frame_end;
	assign result.bit_taken = res_s2.bit_taken;

	// A frame end always drops the armed flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.frame_end |-> !result.receiving)
		else $error("frame_end reported while still receiving");

	// Bits are only taken inside an armed frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.bit_taken |-> result.receiving)
		else $error("bit taken outside an armed frame");

	// A timeout and a decoded bit come from different line phases.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.frame_end && result.bit_taken))
		else $error("frame_end and bit_taken on the same sample");

	// The decode state only moves when a sample leaves stage 1.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> valid_s1)
		else $error("decode stepped without a sample");

endmodule
